>>> src/core_local_timer_interruptor_core_defines.svh
// ----------------------------------------------------------------------------
// Core-local timer interruptor: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CORE_LOCAL_TIMER_INTERRUPTOR_CORE_DEFINES_SVH
`define CORE_LOCAL_TIMER_INTERRUPTOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CLINT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CLINT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/clint_pkg.sv
// ----------------------------------------------------------------------------
// clint_pkg
// Shared constants and codes of the core-local timer interruptor.
// ----------------------------------------------------------------------------
package clint_pkg;

  localparam int MAX_HARTS_DEF = 8;
  localparam int PEND_LANES    = 8;

  localparam logic [31:0] SOFT_IRQ_OFFSET = 32'd0;
  localparam logic [31:0] COMPARE_OFFSET  = 32'd16384;
  localparam logic [31:0] TIME_OFFSET     = 32'd49144;

  localparam logic [31:0] BASE_ADDRESS_RST = 32'h0200_0000;
  localparam logic [3:0]  HART_COUNT_RST   = 4'd1;

  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 152;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_SKIP    = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_HART_COUNT   = 1'b1
  } cfg_idx_t;

endpackage

>>> src/clint_ram.sv
// ----------------------------------------------------------------------------
// clint_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clint_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/core_local_timer_interruptor_core.sv
// ----------------------------------------------------------------------------
// core_local_timer_interruptor_core
// Core-local interruptor: time counter, per-hart compare values in RAM and
// per-hart software bits, with a bus-style register window.
//
//   channel | dir | handshake               | payload
//   in_     | in  | in_tvalid / in_tready   | in_tdata, in_tuser
//   out_    | out | out_tvalid / out_tready | out_tdata
//   cfg_    | in  | cfg_we                  | cfg_index, cfg_wdata
//
// The result is loaded after the item passes S_DEC, S_EXEC, S_PEND and S_OUT;
// S_PEND scans P = min(active harts, 8) harts, and a skip adds S_MIN, which
// scans all A = active harts, and S_SKIP, as the compare RAM's single read port
// is scanned one hart per cycle. Compare entries carry valid bits cleared by
// reset, so no clearing pass is needed. The result sits in an output register;
// while it waits the engine holds in its final state before loading the next.
// ----------------------------------------------------------------------------
`include "core_local_timer_interruptor_core_defines.svh"

module core_local_timer_interruptor_core #(
  parameter int MAX_HARTS = clint_pkg::MAX_HARTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // bus_address[31:0], write_data[95:32], tick_count[159:96]
  input  logic [clint_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[1:0], wide_access[2]
  input  logic [clint_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_data[63:0], unhandled_offset[64], deadline_found[65],
  // timer_pending[73:66], software_pending[81:74], time_now[145:82], zeros
  output logic [clint_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [clint_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int HW  = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
  localparam int ACW = $clog2(MAX_HARTS + 1);
  localparam int PEND_HARTS = (MAX_HARTS < clint_pkg::PEND_LANES) ?
                              MAX_HARTS : clint_pkg::PEND_LANES;
  localparam logic [31:0] SOFT_SPAN = 32'(4 * MAX_HARTS);
  localparam logic [31:0] CMP_SPAN  = 32'(8 * MAX_HARTS);
  localparam logic [31:0] TIME_HI   = clint_pkg::TIME_OFFSET + 32'd4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MIN  = 7'b0001000,
    S_SKIP = 7'b0010000,
    S_PEND = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic          soft_hit;
    logic          cmp_hit;
    logic          tlo_hit;
    logic          thi_hit;
    logic          hart_ok;
    logic          high;
    logic [HW-1:0] hart;
  } dec_t;

  state_t                 state_r, state_nxt;
  logic [31:0]            base_r, base_nxt;
  logic [3:0]             hcnt_r, hcnt_nxt;
  clint_pkg::func_t       func_r, func_nxt;
  logic [31:0]            addr_r, addr_nxt;
  logic                   wide_r, wide_nxt;
  logic [63:0]            wdata_r, wdata_nxt;
  logic [63:0]            ticks_r, ticks_nxt;
  dec_t                   dec_r, dec_nxt, dec_c;
  logic [63:0]            time_r, time_nxt;
  logic [MAX_HARTS-1:0]   soft_r, soft_nxt;
  logic [MAX_HARTS-1:0]   cvld_r, cvld_nxt;
  logic                   vld_q_r;
  logic [ACW-1:0]         cnt_r, cnt_nxt;
  logic                   proc_vld_r, proc_vld_nxt;
  logic [HW-1:0]          proc_idx_r, proc_idx_nxt;
  logic [63:0]            earliest_r, earliest_nxt;
  logic [7:0]             tp_r, tp_nxt;
  logic [63:0]            rdata_r, rdata_nxt;
  logic                   miss_r, miss_nxt;
  logic                   found_r, found_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [clint_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                   ram_we, ram_re;
  logic [HW-1:0]          ram_waddr, ram_raddr;
  logic [63:0]            ram_wdata, ram_rdata;

  logic [31:0]            act32, pend32;
  logic [ACW-1:0]         scan_n;
  logic                   issue;
  logic [63:0]            vdata;
  logic                   pend_ge;
  logic [7:0]             tp_hit, sp_vec;
  logic [31:0]            off, soft_rel, cmp_rel, hart32;
  logic                   soft_in, cmp_in;

  clint_ram #(
    .WIDTH (64),
    .DEPTH (MAX_HARTS)
  ) u_cmp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign act32  = (32'(hcnt_r) < 32'(MAX_HARTS)) ? 32'(hcnt_r) : 32'(MAX_HARTS);
  assign pend32 = (act32 < 32'(PEND_HARTS)) ? act32 : 32'(PEND_HARTS);
  assign scan_n = (state_r == S_MIN) ? act32[ACW-1:0] : pend32[ACW-1:0];
  assign issue  = cnt_r < scan_n;
  assign vdata  = vld_q_r ? ram_rdata : '1;
  assign pend_ge = time_r >= vdata;

  // address decode
  assign off      = addr_r - base_r;
  assign soft_rel = off - clint_pkg::SOFT_IRQ_OFFSET;
  assign cmp_rel  = off - clint_pkg::COMPARE_OFFSET;
  assign soft_in  = (off >= clint_pkg::SOFT_IRQ_OFFSET) && (soft_rel < SOFT_SPAN);
  assign cmp_in   = (off >= clint_pkg::COMPARE_OFFSET) && (cmp_rel < CMP_SPAN);
  assign hart32   = soft_in ? (soft_rel >> 2) : (cmp_rel >> 3);

  always_comb begin
    dec_c.soft_hit = soft_in;
    dec_c.cmp_hit  = !soft_in && cmp_in;
    dec_c.tlo_hit  = !soft_in && !cmp_in && (off == clint_pkg::TIME_OFFSET);
    dec_c.thi_hit  = !soft_in && !cmp_in && (off == TIME_HI);
    dec_c.hart_ok  = hart32 < act32;
    dec_c.high     = cmp_rel[2];
    dec_c.hart     = hart32[HW-1:0];
  end

  for (genvar g = 0; g < clint_pkg::PEND_LANES; g++) begin : g_lane
    if (g < PEND_HARTS) begin : g_on
      assign tp_hit[g] = proc_vld_r && (proc_idx_r == HW'(g));
      assign sp_vec[g] = soft_r[g] && (32'(g) < act32);
    end else begin : g_off
      assign tp_hit[g] = 1'b0;
      assign sp_vec[g] = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    hcnt_nxt       = hcnt_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    wide_nxt       = wide_r;
    wdata_nxt      = wdata_r;
    ticks_nxt      = ticks_r;
    dec_nxt        = dec_r;
    time_nxt       = time_r;
    soft_nxt       = soft_r;
    cvld_nxt       = cvld_r;
    cnt_nxt        = cnt_r;
    proc_vld_nxt   = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    earliest_nxt   = earliest_r;
    tp_nxt         = tp_r;
    rdata_nxt      = rdata_r;
    miss_nxt       = miss_r;
    found_nxt      = found_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = dec_r.hart;
    ram_wdata      = wdata_r;
    ram_re         = 1'b0;
    ram_raddr      = cnt_r[HW-1:0];

    if (cfg_we) begin
      unique case (clint_pkg::cfg_idx_t'(cfg_index))
        clint_pkg::CFG_BASE_ADDRESS: base_nxt = cfg_wdata;
        clint_pkg::CFG_HART_COUNT:   hcnt_nxt = cfg_wdata[3:0];
        default: ;
      endcase
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = clint_pkg::func_t'(in_tuser[1:0]);
          wide_nxt  = in_tuser[2];
          addr_nxt  = in_tdata[31:0];
          wdata_nxt = in_tdata[95:32];
          ticks_nxt = in_tdata[159:96];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        dec_nxt   = dec_c;
        ram_re    = dec_c.cmp_hit && dec_c.hart_ok;
        ram_raddr = dec_c.hart;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        rdata_nxt    = '0;
        miss_nxt     = 1'b0;
        found_nxt    = 1'b0;
        cnt_nxt      = '0;
        tp_nxt       = '0;
        earliest_nxt = '1;
        unique case (func_r)
          clint_pkg::FUNC_READ, clint_pkg::FUNC_WRITE: begin
            priority if (dec_r.soft_hit) begin
              if (dec_r.hart_ok) begin
                if (func_r == clint_pkg::FUNC_WRITE) begin
                  soft_nxt[dec_r.hart] = wdata_r[0];
                end else begin
                  rdata_nxt = {63'b0, soft_r[dec_r.hart]};
                end
              end
            end else if (dec_r.cmp_hit) begin
              if (dec_r.hart_ok) begin
                if (func_r == clint_pkg::FUNC_WRITE) begin
                  ram_we = 1'b1;
                  cvld_nxt[dec_r.hart] = 1'b1;
                  if (wide_r) begin
                    ram_wdata = wdata_r;
                  end else if (dec_r.high) begin
                    ram_wdata = {wdata_r[31:0], vdata[31:0]};
                  end else begin
                    ram_wdata = {vdata[63:32], wdata_r[31:0]};
                  end
                end else if (wide_r) begin
                  rdata_nxt = vdata;
                end else if (dec_r.high) begin
                  rdata_nxt = {32'b0, vdata[63:32]};
                end else begin
                  rdata_nxt = {32'b0, vdata[31:0]};
                end
              end
            end else if (dec_r.tlo_hit) begin
              if (func_r == clint_pkg::FUNC_WRITE) begin
                time_nxt = wide_r ? wdata_r : {time_r[63:32], wdata_r[31:0]};
              end else begin
                rdata_nxt = wide_r ? time_r : {32'b0, time_r[31:0]};
              end
            end else if (dec_r.thi_hit) begin
              if (func_r == clint_pkg::FUNC_WRITE) begin
                time_nxt = {wdata_r[31:0], time_r[31:0]};
              end else begin
                rdata_nxt = {32'b0, time_r[63:32]};
              end
            end else begin
              miss_nxt = 1'b1;
            end
          end
          clint_pkg::FUNC_ADVANCE: time_nxt = time_r + ticks_r;
          clint_pkg::FUNC_SKIP: ;
          default: ;
        endcase
        state_nxt = (func_r == clint_pkg::FUNC_SKIP) ? S_MIN : S_PEND;
      end
      S_MIN: begin
        if (issue) begin
          ram_re       = 1'b1;
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = cnt_r[HW-1:0];
          cnt_nxt      = ACW'(cnt_r + 1'b1);
        end
        if (proc_vld_r && (vdata < earliest_r)) begin
          earliest_nxt = vdata;
        end
        if (!issue) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (earliest_r != '1) begin
          found_nxt = 1'b1;
          if (earliest_r > time_r) begin
            time_nxt = earliest_r;
          end
        end
        cnt_nxt   = '0;
        state_nxt = S_PEND;
      end
      S_PEND: begin
        if (issue) begin
          ram_re       = 1'b1;
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = cnt_r[HW-1:0];
          cnt_nxt      = ACW'(cnt_r + 1'b1);
        end
        for (int i = 0; i < clint_pkg::PEND_LANES; i++) begin
          if (tp_hit[i]) begin
            tp_nxt[i] = pend_ge;
          end
        end
        if (!issue) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'b0, time_r, sp_vec, tp_r, found_r, miss_r, rdata_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= clint_pkg::BASE_ADDRESS_RST;
      hcnt_r       <= clint_pkg::HART_COUNT_RST;
      time_r       <= '0;
      soft_r       <= '0;
      cvld_r       <= '0;
      proc_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_r       <= base_nxt;
      hcnt_r       <= hcnt_nxt;
      time_r       <= time_nxt;
      soft_r       <= soft_nxt;
      cvld_r       <= cvld_nxt;
      proc_vld_r   <= proc_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    wide_r      <= wide_nxt;
    wdata_r     <= wdata_nxt;
    ticks_r     <= ticks_nxt;
    dec_r       <= dec_nxt;
    cnt_r       <= cnt_nxt;
    proc_idx_r  <= proc_idx_nxt;
    earliest_r  <= earliest_nxt;
    tp_r        <= tp_nxt;
    rdata_r     <= rdata_nxt;
    miss_r      <= miss_nxt;
    found_r     <= found_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (ram_re) begin
      vld_q_r <= cvld_r[ram_raddr];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `CLINT_ASSERT_SAME(a_no_write_in_scan, (state_r == S_MIN) || (state_r == S_PEND), !ram_we, "compare RAM written during a scan")
  `CLINT_ASSERT_NEXT(a_skip_forward, state_r == S_SKIP, time_r >= $past(time_r), "skip moved time backwards")
  `CLINT_ASSERT_SAME(a_load_from_out, $rose(out_tvalid_r), $past(state_r) == S_OUT, "result loaded outside final state")

endmodule
